/* sv/media_format_sniffer_assert.svh */
// Assertion macros shared by the media format sniffer RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef MEDIA_FORMAT_SNIFFER_ASSERT_SVH
`define MEDIA_FORMAT_SNIFFER_ASSERT_SVH
`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define MFS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("media_format_sniffer assertion failed");
// Consequence that must hold in the cycle after the antecedent.
`define MFS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("media_format_sniffer assertion failed");
`else
`define MFS_ASSERT(lbl, clk, rstn, prop)
`define MFS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* sv/mfs_pkg.sv */
// Package for the media format sniffer: file type codes, header length and
// the result record passed to the output stage. No dependencies.
`timescale 1ns / 1ps

package mfs_pkg;

  localparam logic [3:0] TYPE_UNKNOWN = 4'd0;
  localparam logic [3:0] TYPE_RM      = 4'd1;
  localparam logic [3:0] TYPE_IFF     = 4'd2;
  localparam logic [3:0] TYPE_AVI     = 4'd3;
  localparam logic [3:0] TYPE_FLIC    = 4'd4;
  localparam logic [3:0] TYPE_QT      = 4'd5;
  localparam logic [3:0] TYPE_NSF     = 4'd6;
  localparam logic [3:0] TYPE_AC3     = 4'd7;
  localparam logic [3:0] TYPE_MPA     = 4'd8;
  localparam logic [3:0] TYPE_MPV     = 4'd9;
  localparam logic [3:0] TYPE_MPS     = 4'd10;

  localparam logic [3:0] HEADER_BYTES = 4'd12;

  typedef struct packed {
    logic       valid;
    logic [3:0] file_type;
  } res_t;

endpackage

/* sv/mfs_classify.sv */
// Header classifier: maps the three big-endian header words to a file type.
// Depends on mfs_pkg for the type codes.
`timescale 1ns / 1ps

module mfs_classify
  import mfs_pkg::*;
(
  input  logic [31:0] w0,
  input  logic [31:0] w1,
  input  logic [31:0] w2,
  output logic [3:0]  file_type
);

  localparam logic [31:0] MAGIC_RM   = 32'h2E524D46;
  localparam logic [31:0] MAGIC_FORM = 32'h464F524D;
  localparam logic [31:0] MAGIC_LIST = 32'h4C495354;
  localparam logic [31:0] MAGIC_PROP = 32'h50524F50;
  localparam logic [31:0] MAGIC_RIFF = 32'h52494646;
  localparam logic [31:0] MAGIC_AVI  = 32'h41564920;
  localparam logic [15:0] MAGIC_FLI  = 16'h11AF;
  localparam logic [15:0] MAGIC_FLC  = 16'h12AF;
  localparam logic [31:0] MAGIC_MOOV = 32'h6D6F6F76;
  localparam logic [31:0] MAGIC_MDAT = 32'h6D646174;
  localparam logic [31:0] MAGIC_SKIP = 32'h736B6970;
  localparam logic [31:0] MAGIC_FREE = 32'h66726565;
  localparam logic [31:0] MAGIC_NESM = 32'h4E45534D;
  localparam logic [7:0]  NSF_EOF    = 8'h1A;
  localparam logic [15:0] MAGIC_AC3  = 16'h0B77;
  localparam logic [10:0] MPA_SYNC   = 11'h7FF;

  logic [3:0] t;

  always_comb begin
    t = TYPE_UNKNOWN;
    if (w0 == MAGIC_RM) begin
      t = TYPE_RM;
    end else if (w0 == MAGIC_FORM || w0 == MAGIC_LIST || w0 == MAGIC_PROP) begin
      t = TYPE_IFF;
    end else if (w0 == MAGIC_RIFF) begin
      if (w2 == MAGIC_AVI) begin
        t = TYPE_AVI;
      end
    end else begin
      if (w1[31:16] == MAGIC_FLI || w1[31:16] == MAGIC_FLC) begin
        t = TYPE_FLIC;
      end
      // A zero first word with an mdat atom is too weak to call QuickTime.
      if (w1 == MAGIC_MOOV || (w1 == MAGIC_MDAT && w0 != 32'h0) ||
          w1 == MAGIC_SKIP || w1 == MAGIC_FREE) begin
        t = TYPE_QT;
      end
    end

    if (w0 == MAGIC_NESM && w1[31:24] == NSF_EOF) begin
      t = TYPE_NSF;
    end

    if (t == TYPE_UNKNOWN && w0[31:16] == MAGIC_AC3) begin
      t = TYPE_AC3;
    end

    // Frame sync, a valid layer, a usable bitrate and sample rate.
    if (t == TYPE_UNKNOWN && w0[31:21] == MPA_SYNC && w0[18:17] != 2'b00 &&
        w0[15:12] != 4'hF && w0[11:10] != 2'b11) begin
      t = TYPE_MPA;
    end
  end

  assign file_type = t;

endmodule

/* sv/mfs_out_stage.sv */
// Two-entry result buffer between the sniffer logic and the output stream.
// Depends on mfs_pkg for the result record and on the assertion macro header.
`timescale 1ns / 1ps
`include "media_format_sniffer_assert.svh"

module mfs_out_stage
  import mfs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  res_t       push_res,
  output logic       push_ready,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata    // [3:0] file_type, [7:4] zero
);

  logic [1:0] count_r, count_nxt;
  logic [3:0] head_r, head_nxt;
  logic [3:0] skid_r, skid_nxt;
  logic       pop;
  logic       push;

  assign pop        = out_tvalid && out_tready;
  assign push       = push_res.valid;
  assign push_ready = (count_r != 2'd2);
  assign out_tvalid = (count_r != 2'd0);
  assign out_tdata  = {4'h0, head_r};

  always_comb begin
    count_nxt = count_r;
    head_nxt  = head_r;
    skid_nxt  = skid_r;
    case (count_r)
      2'd0: begin
        if (push) begin
          head_nxt  = push_res.file_type;
          count_nxt = 2'd1;
        end
      end
      2'd1: begin
        if (push && pop) begin
          head_nxt = push_res.file_type;
        end else if (push) begin
          skid_nxt  = push_res.file_type;
          count_nxt = 2'd2;
        end else if (pop) begin
          count_nxt = 2'd0;
        end
      end
      2'd2: begin
        if (pop) begin
          head_nxt  = skid_r;
          count_nxt = 2'd1;
        end
      end
      default: begin
        count_nxt = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  `MFS_ASSERT(a_count_range, clk, rst_n, count_r != 2'd3)
  `MFS_ASSERT(a_full_no_push, clk, rst_n, !(count_r == 2'd2 && push))
  `MFS_ASSERT_NEXT(a_skid_moves_up, clk, rst_n, count_r == 2'd2 && pop, count_r == 2'd1 && head_r == $past(skid_r))

endmodule

/* sv/media_format_sniffer.sv */
// Top level of the media format sniffer: byte intake, header capture,
// start-code scan and result push. Depends on mfs_pkg, mfs_classify,
// mfs_out_stage and the assertion macro header.
//
// Usage: the file is streamed in one byte per transfer on the in_ channel,
// in file order, with in_tlast high on the final byte. For each file exactly
// one file_type is delivered on the out_ channel, and the block then rearms
// for the next file. The type is decided when the twelfth byte arrives, or at
// the final byte of a shorter file; if the header matches no known format the
// MPEG start-code scan decides, which may take until the end of the file.
// Bytes after the answer are taken and dropped until in_tlast.
// Throughput is one byte per cycle while in_tready is high: each byte is handled by one pass of the
// capture, scan and classify logic between the state registers and the
// two-entry result buffer. A result is visible on out_tvalid in the cycle after
// the transfer of the byte that decides it.
// Reset clears the header, scan state and result buffer. While the receiver
// stalls, the buffer holds up to two results and in_tready drops only when
// both entries are full.
`timescale 1ns / 1ps
`include "media_format_sniffer_assert.svh"

module media_format_sniffer
  import mfs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // [7:0] file_byte
  input  logic       in_tlast,    // last_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata    // [3:0] file_type, [7:4] zero
);

  localparam logic [23:0] START_PREFIX = 24'h000001;
  localparam logic [7:0]  CODE_VIDEO   = 8'hB3;
  localparam logic [7:0]  CODE_SYSTEM  = 8'hBA;
  localparam logic [3:0]  SCAN_MIN     = 4'd4;

  logic [31:0] w0_r, w0_nxt;
  logic [31:0] w1_r, w1_nxt;
  logic [31:0] w2_r, w2_nxt;
  logic [3:0]  bytes_seen_r, bytes_seen_nxt;
  logic [31:0] window_r, window_nxt;
  logic [3:0]  scan_out_r, scan_out_nxt;
  logic        scan_done_r, scan_done_nxt;
  logic        answer_r, answer_nxt;

  logic        in_fire;
  logic        hdr_done;
  logic        hdr_end;
  logic [31:0] ins;
  logic [3:0]  hdr_type;
  res_t        res;

  assign in_fire  = in_tvalid && in_tready;
  assign hdr_done = (bytes_seen_r == HEADER_BYTES);
  // New byte placed big-endian at its slot inside the current header word.
  assign ins      = {in_tdata, 24'h0} >> {bytes_seen_r[1:0], 3'b000};

  mfs_classify u_classify (
    .w0        (w0_nxt),
    .w1        (w1_nxt),
    .w2        (w2_nxt),
    .file_type (hdr_type)
  );

  always_comb begin
    w0_nxt         = w0_r;
    w1_nxt         = w1_r;
    w2_nxt         = w2_r;
    bytes_seen_nxt = bytes_seen_r;
    window_nxt     = window_r;
    scan_out_nxt   = scan_out_r;
    scan_done_nxt  = scan_done_r;
    hdr_end        = 1'b0;
    res.valid      = 1'b0;
    res.file_type  = TYPE_UNKNOWN;
    if (!answer_r) begin
      if (!hdr_done) begin
        case (bytes_seen_r[3:2])
          2'd0:    w0_nxt = w0_r | ins;
          2'd1:    w1_nxt = w1_r | ins;
          default: w2_nxt = w2_r | ins;
        endcase
        bytes_seen_nxt = bytes_seen_r + 4'd1;
      end
      if (!scan_done_r) begin
        window_nxt = {window_r[23:0], in_tdata};
        if (bytes_seen_nxt >= SCAN_MIN && window_nxt[31:8] == START_PREFIX) begin
          scan_done_nxt = 1'b1;
          case (window_nxt[7:0])
            CODE_VIDEO:  scan_out_nxt = TYPE_MPV;
            CODE_SYSTEM: scan_out_nxt = TYPE_MPS;
            default:     scan_out_nxt = TYPE_UNKNOWN;
          endcase
        end
      end
      hdr_end = (bytes_seen_nxt == HEADER_BYTES) || in_tlast;
      if (!hdr_done && hdr_end && hdr_type != TYPE_UNKNOWN) begin
        res.valid     = 1'b1;
        res.file_type = hdr_type;
      end else if (hdr_end) begin
        if (scan_done_nxt) begin
          res.valid     = 1'b1;
          res.file_type = scan_out_nxt;
        end else if (in_tlast) begin
          res.valid     = 1'b1;
          res.file_type = TYPE_UNKNOWN;
        end
      end
    end
    answer_nxt = answer_r | res.valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w0_r         <= 32'h0;
      w1_r         <= 32'h0;
      w2_r         <= 32'h0;
      bytes_seen_r <= 4'd0;
      window_r     <= 32'h0;
      scan_out_r   <= TYPE_UNKNOWN;
      scan_done_r  <= 1'b0;
      answer_r     <= 1'b0;
    end else if (in_fire) begin
      if (in_tlast) begin
        // The final byte of a file rearms everything for the next one.
        w0_r         <= 32'h0;
        w1_r         <= 32'h0;
        w2_r         <= 32'h0;
        bytes_seen_r <= 4'd0;
        window_r     <= 32'h0;
        scan_out_r   <= TYPE_UNKNOWN;
        scan_done_r  <= 1'b0;
        answer_r     <= 1'b0;
      end else begin
        w0_r         <= w0_nxt;
        w1_r         <= w1_nxt;
        w2_r         <= w2_nxt;
        bytes_seen_r <= bytes_seen_nxt;
        window_r     <= window_nxt;
        scan_out_r   <= scan_out_nxt;
        scan_done_r  <= scan_done_nxt;
        answer_r     <= answer_nxt;
      end
    end
  end

  res_t push_res;
  assign push_res.valid     = res.valid && in_fire;
  assign push_res.file_type = res.file_type;

  mfs_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_res   (push_res),
    .push_ready (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  `MFS_ASSERT_NEXT(a_rearm_after_last, clk, rst_n, in_fire && in_tlast, bytes_seen_r == 4'd0 && !answer_r && !scan_done_r)

endmodule

/* verif/mfs_checker.sv */
// Result checker for the media format sniffer: watches both stream channels,
// predicts the file type of each file from its bytes and compares the results.
// Depends on mfs_pkg for the type codes and the header length.
`timescale 1ns / 1ps

module mfs_checker
  import mfs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,    // [7:0] file_byte
  input  logic       in_tlast,    // last_byte
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,   // [3:0] file_type, [7:4] zero
  input  logic       end_check,
  output int         fail_count,
  output int         types_awaited
);

  localparam logic [31:0] MAGIC_RMF  = 32'h2E524D46;
  localparam logic [31:0] MAGIC_FORM = 32'h464F524D;
  localparam logic [31:0] MAGIC_LIST = 32'h4C495354;
  localparam logic [31:0] MAGIC_PROP = 32'h50524F50;
  localparam logic [31:0] MAGIC_RIFF = 32'h52494646;
  localparam logic [31:0] MAGIC_AVI  = 32'h41564920;
  localparam logic [31:0] MAGIC_MOOV = 32'h6D6F6F76;
  localparam logic [31:0] MAGIC_MDAT = 32'h6D646174;
  localparam logic [31:0] MAGIC_SKIP = 32'h736B6970;
  localparam logic [31:0] MAGIC_FREE = 32'h66726565;
  localparam logic [31:0] MAGIC_NESM = 32'h4E45534D;
  localparam logic [7:0]  CODE_VIDEO = 8'hB3;
  localparam logic [7:0]  CODE_PACK  = 8'hBA;

  logic [31:0] hdr_word [3];
  logic [3:0]  hdr_count;
  logic [31:0] scan_window;
  logic [3:0]  scan_type;
  logic        scan_hit;
  logic        type_sent;
  logic        leftovers_checked;
  logic [3:0]  want;
  logic [3:0]  awaited_types [$];

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  function automatic logic [3:0] header_type(input logic [31:0] w0, input logic [31:0] w1,
                                             input logic [31:0] w2);
    logic [3:0] t;
    t = TYPE_UNKNOWN;
    if (w0 == MAGIC_RMF) begin
      t = TYPE_RM;
    end else if (w0 == MAGIC_FORM || w0 == MAGIC_LIST || w0 == MAGIC_PROP) begin
      t = TYPE_IFF;
    end else if (w0 == MAGIC_RIFF) begin
      if (w2 == MAGIC_AVI) t = TYPE_AVI;
    end else begin
      if (w1[31:16] == 16'h11AF || w1[31:16] == 16'h12AF) t = TYPE_FLIC;
      // QuickTime overrides FLIC when both appear to match.
      if (w1 == MAGIC_MOOV || (w1 == MAGIC_MDAT && w0 != 32'h0) ||
          w1 == MAGIC_SKIP || w1 == MAGIC_FREE) t = TYPE_QT;
    end
    if (w0 == MAGIC_NESM && w1[31:24] == 8'h1A) t = TYPE_NSF;
    if (t == TYPE_UNKNOWN && w0[31:16] == 16'h0B77) t = TYPE_AC3;
    // Frame sync, then reject reserved layer, bad bitrate and reserved rate.
    if (t == TYPE_UNKNOWN && w0[31:21] == 11'h7FF && w0[18:17] != 2'b00 &&
        w0[15:12] != 4'hF && w0[11:10] != 2'b11) t = TYPE_MPA;
    return t;
  endfunction

  task automatic rearm();
    hdr_word[0] = '0;
    hdr_word[1] = '0;
    hdr_word[2] = '0;
    hdr_count   = '0;
    scan_window = '0;
    scan_type   = TYPE_UNKNOWN;
    scan_hit    = 1'b0;
    type_sent   = 1'b0;
  endtask

  task automatic sniff_byte(input logic [7:0] b, input logic final_byte);
    logic       header_was_full;
    logic       decided;
    logic [3:0] found;
    decided = 1'b0;
    found = TYPE_UNKNOWN;
    if (!type_sent) begin
      header_was_full = (hdr_count >= HEADER_BYTES);
      if (!header_was_full) begin
        hdr_word[hdr_count[3:2]] |= {24'h0, b} << (8 * (3 - hdr_count[1:0]));
        hdr_count++;
      end
      if (!scan_hit) begin
        scan_window = {scan_window[23:0], b};
        // A start code counts only once four bytes of this file have arrived.
        if (hdr_count >= 4 && scan_window[31:8] == 24'h000001) begin
          scan_hit = 1'b1;
          case (b)
            CODE_VIDEO: scan_type = TYPE_MPV;
            CODE_PACK:  scan_type = TYPE_MPS;
            default:    scan_type = TYPE_UNKNOWN;
          endcase
        end
      end
      if (!header_was_full && (hdr_count >= HEADER_BYTES || final_byte)) begin
        found = header_type(hdr_word[0], hdr_word[1], hdr_word[2]);
        decided = (found != TYPE_UNKNOWN);
      end
      // With no header match, a held start code decides, or the end of the file.
      if (!decided && (hdr_count >= HEADER_BYTES || final_byte) && (scan_hit || final_byte)) begin
        found = scan_hit ? scan_type : TYPE_UNKNOWN;
        decided = 1'b1;
      end
      if (decided) begin
        type_sent = 1'b1;
        awaited_types.push_back(found);
      end
    end
    if (final_byte) rearm();
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      rearm();
      awaited_types.delete();
      fail_count = 0;
      leftovers_checked = 1'b0;
    end else begin
      if (in_tvalid && in_tready) sniff_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (awaited_types.size() == 0) begin
          report_mismatch($sformatf("result with none expected, file_type %0d",
                                    out_tdata[3:0]));
        end else begin
          want = awaited_types.pop_front();
          if (out_tdata[3:0] != want)
            report_mismatch($sformatf("file_type %0d, expected %0d", out_tdata[3:0], want));
          if (out_tdata[7:4] != 4'h0)
            report_mismatch($sformatf("pad bits of tdata are %h", out_tdata[7:4]));
        end
      end
      if (end_check && !leftovers_checked) begin
        leftovers_checked = 1'b1;
        if (awaited_types.size() != 0)
          report_mismatch($sformatf("%0d expected file types never arrived",
                                    awaited_types.size()));
      end
    end
    types_awaited = awaited_types.size();
  end

endmodule

/* verif/tb.sv */
// Testbench top for the media format sniffer: clock, reset, file stimulus with
// sender gaps and receiver stalls, watchdog and verdict. Depends on mfs_pkg,
// the media_format_sniffer RTL and mfs_checker.
`timescale 1ns / 1ps

module tb;
  import mfs_pkg::*;

  localparam int HOLD_CYCLES = 60;
  // Far above the receiver hold-off plus the longest random stall runs.
  localparam int STALL_LIMIT = 1000;

  typedef enum int {
    KIND_NOISE, KIND_RM, KIND_IFF, KIND_RIFF, KIND_FLIC, KIND_QT, KIND_NSF,
    KIND_AC3, KIND_MPA, KIND_MPV, KIND_MPS, KIND_CODE
  } file_kind_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tlast = 1'b0;
  logic       out_tready = 1'b0;
  logic       end_check = 1'b0;
  logic       hold_req = 1'b0;
  wire        in_tready;
  wire        out_tvalid;
  wire  [7:0] out_tdata;
  int         fail_count;
  int         types_awaited;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         quiet_cycles = 0;
  logic [7:0] file_q [$];

  media_format_sniffer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  mfs_checker u_type_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tlast      (in_tlast),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .end_check     (end_check),
    .fail_count    (fail_count),
    .types_awaited (types_awaited)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off when requested.
  initial begin
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Called at a rising edge; returns at the edge where the transfer happens.
  task automatic push_byte(input logic [7:0] b, input logic final_byte);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= final_byte;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic put_word(input int pos, input logic [31:0] w);
    for (int i = 0; i < 4; i++)
      if (pos + i < file_q.size()) file_q[pos + i] = w[31 - 8 * i -: 8];
  endtask

  task automatic build_file(input file_kind_t kind, input int len);
    logic [31:0] w;
    logic [7:0]  code;
    int          pos;
    file_q.delete();
    repeat (len) file_q.push_back(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom));
    case (kind)
      KIND_RM: put_word(0, 32'h2E524D46);
      KIND_IFF: begin
        case ($urandom_range(0, 2))
          0: w = 32'h464F524D;
          1: w = 32'h4C495354;
          default: w = 32'h50524F50;
        endcase
        put_word(0, w);
      end
      KIND_RIFF: begin
        put_word(0, 32'h52494646);
        if ($urandom_range(0, 3) != 0) put_word(8, 32'h41564920);
      end
      KIND_FLIC: put_word(4, {($urandom_range(0, 1) ? 16'h11AF : 16'h12AF), 16'($urandom)});
      KIND_QT: begin
        case ($urandom_range(0, 3))
          0: w = 32'h6D6F6F76;
          1: w = 32'h6D646174;
          2: w = 32'h736B6970;
          default: w = 32'h66726565;
        endcase
        put_word(4, w);
        // An all-zero first word disqualifies the mdat form.
        if ($urandom_range(0, 2) == 0) put_word(0, 32'h0);
      end
      KIND_NSF: begin
        put_word(0, 32'h4E45534D);
        put_word(4, {8'h1A, 24'($urandom)});
      end
      KIND_AC3: put_word(0, {16'h0B77, 16'($urandom)});
      KIND_MPA: put_word(0, {11'h7FF, 21'($urandom)});
      KIND_MPV, KIND_MPS, KIND_CODE: begin
        if (kind == KIND_MPV) code = 8'hB3;
        else if (kind == KIND_MPS) code = 8'hBA;
        else code = 8'($urandom);
        pos = $urandom_range(0, len - 1);
        put_word(pos, {24'h000001, code});
      end
      default: ;
    endcase
  endtask

  task automatic send_file();
    for (int i = 0; i < file_q.size(); i++) push_byte(file_q[i], i == file_q.size() - 1);
  endtask

  // Drops valid and waits for every awaited result.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (types_awaited != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int byte_goal);
    int sent;
    int files;
    int len;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    files = 0;
    while (sent < byte_goal || files < 6) begin
      case ($urandom_range(0, 9))
        0, 1: len = $urandom_range(1, 11);
        9: len = $urandom_range(21, 48);
        default: len = $urandom_range(12, 20);
      endcase
      build_file(file_kind_t'($urandom_range(0, KIND_CODE)), len);
      send_file();
      sent += len;
      files++;
    end
    settle();
  endtask

  initial begin
    logic [39:0] pack_file;
    logic [95:0] avi_header;
    pack_file  = 40'h000001BA00;
    avi_header = {32'h52494646, 32'h00000000, 32'h41564920};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // One-byte file of all ones: too short for anything, so unknown.
    push_byte(8'hFF, 1'b1);
    // A start code that ends before the fourth byte is never seen.
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h01, 1'b1);
    // Short file with a pack start code inside the zero-padded header.
    for (int i = 0; i < 5; i++) push_byte(pack_file[39 - 8 * i -: 8], i == 4);
    // Full AVI header, then one byte after the answer that must be dropped.
    for (int i = 0; i < 12; i++) push_byte(avi_header[95 - 8 * i -: 8], 1'b0);
    push_byte(8'h00, 1'b1);
    settle();

    run_phase(0, 0, 125);

    // Receiver closes for a long stretch while short files keep arriving.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1'b1;
    repeat (10) begin
      build_file(file_kind_t'($urandom_range(0, KIND_CODE)), $urandom_range(1, 3));
      send_file();
    end
    settle();

    run_phase(69, 0, 125);
    run_phase(0, 69, 125);
    run_phase(36, 36, 125);

    repeat (8) @(posedge clk);
    end_check <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/mfs_pkg.sv
sv/mfs_classify.sv
sv/mfs_out_stage.sv
sv/media_format_sniffer.sv
verif/mfs_checker.sv
verif/tb.sv
